>>> hw/rtl/ntc_pkg.sv
package ntc_pkg;

   localparam int DATA_W = 64;
   localparam int TY_W   = 2;
   localparam int ADDR_W = 3;

   typedef enum logic [TY_W-1:0] {
      TY_F32   = 2'd0,
      TY_I32   = 2'd1,
      TY_I64   = 2'd2,
      TY_OTHER = 2'd3
   } data_kind_type;

   typedef enum logic [ADDR_W-1:0] {
      REG_SOURCE = 3'd0,
      REG_TARGET = 3'd4
   } reg_addr_type;

   typedef enum logic [2:0] {
      OP_PASS    = 3'd0,
      OP_F2I32   = 3'd1,
      OP_F2I64   = 3'd2,
      OP_I2F     = 3'd3,
      OP_TRUNC32 = 3'd4,
      OP_SEXT    = 3'd5
   } op_type;

   // Operation chosen from the source and target element types.
   function automatic op_type select_op(input logic [TY_W-1:0] src,
                                        input logic [TY_W-1:0] dst);
      op_type op;
      op = OP_PASS;
      if (src == TY_F32 && dst == TY_I64) op = OP_F2I64;
      else if (src == TY_F32 && dst == TY_I32) op = OP_F2I32;
      else if ((src == TY_I64 || src == TY_I32) && dst == TY_F32) op = OP_I2F;
      else if (src == TY_I64 && dst == TY_I32) op = OP_TRUNC32;
      else if (src == TY_I32 && dst == TY_I64) op = OP_SEXT;
      return op;
   endfunction

endpackage

>>> hw/rtl/ntc_stage.sv
// One pipeline register slot with its valid bit; holds while stalled.
module ntc_stage #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             valid_in,
   input  logic [WIDTH-1:0] data_in,
   output logic             valid_out,
   output logic [WIDTH-1:0] data_out
);

   logic             valid_ff;
   logic [WIDTH-1:0] data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

>>> hw/rtl/numeric_type_cast.sv
// An accepted request passes the decode, leading one, normalise and round stages
// before its result is on rsp_tdata. Throughput: one request per cycle; the four-stage
// pipeline advances whenever its last stage is empty or its result is being taken.
// Reset: synchronous, active high; clears all valid bits and both type registers
// to float32.
module numeric_type_cast (
   input  logic                      clock,
   input  logic                      reset,
   // Request channel. tdata: value_bits[63:0].
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [ntc_pkg::DATA_W-1:0] req_tdata,
   // Result channel. tdata: result_bits[63:0], out_of_range[64],
   // zero padding above.
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [ntc_pkg::DATA_W+7:0] rsp_tdata,
   // Configuration port.
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [ntc_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   localparam int DATA_W = ntc_pkg::DATA_W;
   localparam int SH_W   = $clog2(DATA_W);

   // Configuration registers.
   logic [ntc_pkg::TY_W-1:0] src_ff, dst_ff;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff <= ntc_pkg::TY_F32;
         dst_ff <= ntc_pkg::TY_F32;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr)
            ntc_pkg::REG_SOURCE: src_ff <= csr_pwdata[ntc_pkg::TY_W-1:0];
            ntc_pkg::REG_TARGET: dst_ff <= csr_pwdata[ntc_pkg::TY_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr)
         ntc_pkg::REG_SOURCE: csr_prdata = {30'd0, src_ff};
         ntc_pkg::REG_TARGET: csr_prdata = {30'd0, dst_ff};
         default:             csr_prdata = 32'd0;
      endcase
   end

   // The whole pipeline moves together; a full last stage that is not taken
   // freezes every stage, so nothing is lost or repeated.
   logic advance;
   logic v1, v2, v3;
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // ---------------- Stage 1: decode ----------------
   // Float fields are split and the integer magnitude is formed (a negate).
   ntc_pkg::op_type op0;
   logic [DATA_W-1:0] ival0, mag0;
   logic              isign0;
   logic [7:0]        ex0;
   assign op0 = ntc_pkg::select_op(src_ff, dst_ff);
   assign ex0 = req_tdata[30:23];
   always_comb begin
      if (src_ff == ntc_pkg::TY_I32)
         ival0 = {{(DATA_W-32){req_tdata[31]}}, req_tdata[31:0]};
      else
         ival0 = req_tdata;
      isign0 = ival0[DATA_W-1];
      mag0   = isign0 ? (~ival0 + 1'b1) : ival0;
   end

   typedef struct packed {
      ntc_pkg::op_type   op;
      logic [DATA_W-1:0] raw;
      logic [DATA_W-1:0] mag;
      logic              isign;
      logic              fsign;
      logic [7:0]        ex;
      logic [22:0]       man;
   } s1_type;

   s1_type s1_in, s1;
   assign s1_in = '{op: op0, raw: req_tdata, mag: mag0, isign: isign0,
                    fsign: req_tdata[31], ex: ex0, man: req_tdata[22:0]};

   ntc_stage #(.WIDTH($bits(s1_type))) u_s1 (
      .clock, .reset, .advance, .valid_in(req_tvalid && req_tready),
      .data_in(s1_in), .valid_out(v1), .data_out(s1));

   // ---------------- Stage 2: leading one / float shift ----------------
   logic [SH_W-1:0] lead1;
   always_comb begin
      lead1 = '0;
      for (int i = 0; i < DATA_W; i++)
         if (s1.mag[i]) lead1 = SH_W'(i);
   end

   // Float to integer: shift the significand by the exponent, left above 23 and right below.
   logic [7:0]        e1;
   logic [DATA_W-1:0] fmag1;
   logic              fsat1, fnan1, fzero1, fmin1;
   logic [7:0]        lim1;
   always_comb begin
      e1     = s1.ex - 8'd127;
      lim1   = (s1.op == ntc_pkg::OP_F2I32) ? 8'd31 : 8'd63;
      fnan1  = (s1.ex == 8'hFF) && (s1.man != '0);
      fzero1 = s1.ex < 8'd127;
      fmin1  = s1.fsign && (e1 == lim1) && (s1.man == '0);
      fsat1  = !fzero1 && (e1 >= lim1) && !fmin1;
      if (e1 >= 8'd23)
         fmag1 = {{(DATA_W-24){1'b0}}, 1'b1, s1.man} << (e1[5:0] - 6'd23);
      else
         fmag1 = {{(DATA_W-24){1'b0}}, 1'b1, s1.man} >> (6'd23 - e1[5:0]);
   end

   typedef struct packed {
      ntc_pkg::op_type   op;
      logic [DATA_W-1:0] raw;
      logic [DATA_W-1:0] mag;
      logic [SH_W-1:0]   p;
      logic              isign;
      logic              fsign;
      logic [DATA_W-1:0] fmag;
      logic              fnan, fzero, fsat, fmin;
   } s2_type;

   s2_type s2_in, s2;
   assign s2_in = '{op: s1.op, raw: s1.raw, mag: s1.mag, p: lead1, isign: s1.isign,
                    fsign: s1.fsign, fmag: fmag1, fnan: fnan1, fzero: fzero1,
                    fsat: fsat1, fmin: fmin1};

   ntc_stage #(.WIDTH($bits(s2_type))) u_s2 (
      .clock, .reset, .advance, .valid_in(v1),
      .data_in(s2_in), .valid_out(v2), .data_out(s2));

   // ---------------- Stage 3: normalise, sticky, float-to-int sign ----------------
   logic [DATA_W-1:0] norm2;
   logic [23:0]       sig2;
   logic              guard2, sticky2;
   logic [DATA_W-1:0] fint2;
   always_comb begin
      norm2   = s2.mag << (SH_W'(DATA_W-1) - s2.p);
      sig2    = norm2[DATA_W-1 -: 24];
      guard2  = norm2[DATA_W-25];
      sticky2 = |norm2[DATA_W-26:0];
      fint2   = s2.fsign ? (~s2.fmag + 1'b1) : s2.fmag;
   end

   typedef struct packed {
      ntc_pkg::op_type   op;
      logic [DATA_W-1:0] raw;
      logic              zero;
      logic [SH_W-1:0]   p;
      logic              isign;
      logic [23:0]       sig;
      logic              guard, sticky;
      logic              fsign;
      logic [DATA_W-1:0] fint;
      logic              fnan, fzero, fsat, fmin;
   } s3_type;

   s3_type s3_in, s3;
   assign s3_in = '{op: s2.op, raw: s2.raw, zero: (s2.mag == '0), p: s2.p,
                    isign: s2.isign, sig: sig2, guard: guard2, sticky: sticky2,
                    fsign: s2.fsign, fint: fint2, fnan: s2.fnan, fzero: s2.fzero,
                    fsat: s2.fsat, fmin: s2.fmin};

   ntc_stage #(.WIDTH($bits(s3_type))) u_s3 (
      .clock, .reset, .advance, .valid_in(v2),
      .data_in(s3_in), .valid_out(v3), .data_out(s3));

   // ---------------- Stage 4: round and assemble ----------------
   logic [24:0]       rsig3;
   logic [7:0]        fexp3;
   logic [31:0]       fbits3;
   logic [DATA_W-1:0] res3, maxp3;
   logic              oor3;
   always_comb begin
      rsig3  = {1'b0, s3.sig} + 25'(s3.guard && (s3.sticky || s3.sig[0]));
      fexp3  = 8'd127 + 8'(s3.p) + 8'(rsig3[24]);
      fbits3 = {s3.isign, fexp3, rsig3[24] ? rsig3[23:1] : rsig3[22:0]};
      maxp3  = (s3.op == ntc_pkg::OP_F2I32) ? 64'h7FFF_FFFF : 64'h7FFF_FFFF_FFFF_FFFF;
      oor3   = 1'b0;
      res3   = s3.raw;
      case (s3.op)
         ntc_pkg::OP_F2I32, ntc_pkg::OP_F2I64: begin
            if (s3.fnan) begin
               res3 = '0; oor3 = 1'b1;
            end else if (s3.fzero) begin
               res3 = '0;
            end else if (s3.fmin) begin
               res3 = maxp3 + 1'b1;
            end else if (s3.fsat) begin
               res3 = s3.fsign ? maxp3 + 1'b1 : maxp3; oor3 = 1'b1;
            end else begin
               res3 = (s3.op == ntc_pkg::OP_F2I32) ? {32'd0, s3.fint[31:0]} : s3.fint;
            end
         end
         ntc_pkg::OP_I2F:     res3 = s3.zero ? '0 : {32'd0, fbits3};
         ntc_pkg::OP_TRUNC32: res3 = {32'd0, s3.raw[31:0]};
         ntc_pkg::OP_SEXT:    res3 = {{32{s3.raw[31]}}, s3.raw[31:0]};
         default:             res3 = s3.raw;
      endcase
   end

   logic [DATA_W:0] out_data;
   ntc_stage #(.WIDTH(DATA_W+1)) u_s4 (
      .clock, .reset, .advance, .valid_in(v3),
      .data_in({oor3, res3}), .valid_out(rsp_tvalid), .data_out(out_data));

   assign rsp_tdata = {7'd0, out_data};

endmodule

>>> hw/rtl/ntc_checker.sv
module ntc_assertions (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata
);

   // Padding bits above the flag stay clear.
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[71:65] == 7'd0)
      else $error("padding bits set");

   // A stalled result holds its data.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // The request side stalls only while a result waits.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request stalled without back-pressure");

   // No result appears from an empty pipe after reset.
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result after reset");

endmodule

bind numeric_type_cast ntc_assertions u_ntc_assertions (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata);

>>> tb/ntc_checker.sv
module ntc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          mismatches,
   output int          pending,
   output int          checked
);

   typedef struct packed {
      logic [63:0] bits;
      logic        oor;
   } cast_result_type;

   cast_result_type        expected_q[$];
   ntc_pkg::data_kind_type src_ty, dst_ty;

   // Float32 to a signed integer of the given width, truncating toward zero.
   function automatic cast_result_type float_to_int(logic [31:0] f, int width);
      cast_result_type r;
      logic [7:0]      ex;
      logic [63:0]     mask, maxpos, minneg, mag, sig;
      int              e;
      ex     = f[30:23];
      mask   = (width == 32) ? 64'hFFFF_FFFF : '1;
      maxpos = (width == 32) ? 64'h7FFF_FFFF : 64'h7FFF_FFFF_FFFF_FFFF;
      minneg = maxpos + 64'd1;
      r      = '0;
      if (ex == 8'hFF && f[22:0] != 0) begin
         r.oor = 1'b1;
      end else if (ex >= 8'd127) begin
         e = int'(ex) - 127;
         if (e >= width - 1) begin
            if (f[31] && e == width - 1 && f[22:0] == 0) begin
               r.bits = minneg & mask;
            end else begin
               r.oor  = 1'b1;
               r.bits = (f[31] ? minneg : maxpos) & mask;
            end
         end else begin
            sig    = {40'd0, 1'b1, f[22:0]};
            mag    = (e >= 23) ? sig << (e - 23) : sig >> (23 - e);
            r.bits = (f[31] ? -mag : mag) & mask;
         end
      end
      return r;
   endfunction

   // Signed 64-bit integer to float32, round to nearest even.
   function automatic logic [63:0] int_to_float(logic [63:0] v);
      logic [63:0] mag, sig, rem, half;
      int          p, sh;
      mag = v[63] ? -v : v;
      if (mag == 0) return '0;
      p = 0;
      for (int i = 63; i > 0; i--) begin
         if (mag[i]) begin
            p = i;
            break;
         end
      end
      if (p <= 23) begin
         sig = mag << (23 - p);
      end else begin
         sh   = p - 23;
         sig  = mag >> sh;
         rem  = mag & ((64'd1 << sh) - 1);
         half = 64'd1 << (sh - 1);
         if (rem > half || (rem == half && sig[0])) sig++;
         if (sig == (64'd1 << 24)) begin
            sig = sig >> 1;
            p++;
         end
      end
      return {32'd0, v[63], 8'(127 + p), sig[22:0]};
   endfunction

   function automatic cast_result_type convert(logic [63:0] x);
      cast_result_type r;
      r = '{bits: x, oor: 1'b0};
      if (src_ty == ntc_pkg::TY_F32 && dst_ty == ntc_pkg::TY_I64)
         r = float_to_int(x[31:0], 64);
      else if (src_ty == ntc_pkg::TY_F32 && dst_ty == ntc_pkg::TY_I32)
         r = float_to_int(x[31:0], 32);
      else if (src_ty == ntc_pkg::TY_I64 && dst_ty == ntc_pkg::TY_F32)
         r.bits = int_to_float(x);
      else if (src_ty == ntc_pkg::TY_I32 && dst_ty == ntc_pkg::TY_F32)
         r.bits = int_to_float({{32{x[31]}}, x[31:0]});
      else if (src_ty == ntc_pkg::TY_I64 && dst_ty == ntc_pkg::TY_I32)
         r.bits = {32'd0, x[31:0]};
      else if (src_ty == ntc_pkg::TY_I32 && dst_ty == ntc_pkg::TY_I64)
         r.bits = {{32{x[31]}}, x[31:0]};
      return r;
   endfunction

   always @(posedge clock) begin
      cast_result_type want, got;
      if (reset) begin
         src_ty     = ntc_pkg::TY_F32;
         dst_ty     = ntc_pkg::TY_F32;
         mismatches = 0;
         checked    = 0;
         expected_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == ntc_pkg::REG_SOURCE)
               src_ty = ntc_pkg::data_kind_type'(csr_pwdata[1:0]);
            else if (csr_paddr == ntc_pkg::REG_TARGET)
               dst_ty = ntc_pkg::data_kind_type'(csr_pwdata[1:0]);
         end
         if (req_tvalid && req_tready) expected_q.push_back(convert(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = '{bits: rsp_tdata[63:0], oor: rsp_tdata[64]};
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result %h/%b", got.bits, got.oor);
            end else begin
               want = expected_q.pop_front();
               checked++;
               if (got !== want || rsp_tdata[71:65] !== 0) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %h/%b, got %h/%b (pad %h)",
                              want.bits, want.oor, got.bits, got.oor, rsp_tdata[71:65]);
               end
            end
         end
      end
      pending = expected_q.size();
   end
endmodule

>>> tb/tb.sv
// Stimulus and verdict for the numeric type cast. The checker beside the
// block predicts every result; this module only drives the request stream,
// the result back-pressure and the configuration port.
module tb;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // value_bits[63:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;        // result_bits[63:0], out_of_range[64], zeros above
   logic        csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int mismatches, pending, checked;
   int send_idle_pct, recv_idle_pct;
   int settings_seen;

   always #1 clock = ~clock;

   numeric_type_cast i_dut (.*);

   ntc_checker i_checker (.*);

   // The receiver stalls at random with the current percentage, changed
   // only at the falling edge so that the block sees a stable ready.
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic write_reg(ntc_pkg::reg_addr_type addr, logic [31:0] value);
      @(negedge clock);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= addr;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Lowers the request valid, waits until every prediction has been
   // matched, then lets the pipeline drain for its latency before the
   // types may change.
   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic set_types(ntc_pkg::data_kind_type src, ntc_pkg::data_kind_type dst);
      drain();
      // The upper bits of the written word are ignored by the block.
      write_reg(ntc_pkg::REG_SOURCE, {30'($urandom()), src});
      write_reg(ntc_pkg::REG_TARGET, {30'($urandom()), dst});
      settings_seen++;
   endtask

   // One request: the valid stays high from one request to the next unless
   // the sender chooses to idle, so no same-step lowering and raising occurs.
   // Whoever stops sending lowers the valid (see drain).
   task automatic send(logic [63:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Random values leaning toward floats near the integer limits, small
   // magnitudes, specials and integers of random size and either sign.
   function automatic logic [63:0] random_value();
      logic [63:0] v;
      logic [7:0]  ex;
      v = {$urandom(), $urandom()};
      case ($urandom_range(5))
         0: begin
            ex = 8'd150 + 8'($urandom_range(45));
            v[30:23] = ex;
         end
         1: v[30:23] = 8'd100 + 8'($urandom_range(40));
         2: v[30:23] = $urandom_range(1) ? 8'hFF : 8'h00;
         3: v = v >> $urandom_range(63);
         4: v = -(v >> $urandom_range(63));
         default: ;
      endcase
      return v;
   endfunction

   logic [63:0] directed[$] = '{
      64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_3F80_0000, 64'h0000_0000_BF7F_FFFF,
      64'h1234_5678_7F80_0000, 64'h0000_0000_FF80_0000, 64'h0000_0000_7FC0_0001,
      64'h0000_0000_CF00_0000, 64'h0000_0000_DF00_0000, 64'h0000_0000_4F00_0000,
      64'h0000_0000_5F00_0000, 64'h0000_0000_0000_0001, 64'h0000_0000_8000_0000,
      64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h0000_0000_0100_0001,
      64'h0000_0000_0100_0003, 64'hFFFF_FFFF_7FFF_FFFF, 64'h0000_0000_4B7F_FFFF,
      64'hAAAA_AAAA_5555_5555
   };

   initial begin
      ntc_pkg::data_kind_type tys[4];
      tys = '{ntc_pkg::TY_F32, ntc_pkg::TY_I32, ntc_pkg::TY_I64, ntc_pkg::TY_OTHER};
      send_idle_pct = 0;
      recv_idle_pct = 0;
      settings_seen = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: the edge values under the three float-to-integer
      // and integer-to-float pairings most prone to corner cases.
      set_types(ntc_pkg::TY_F32, ntc_pkg::TY_I32);
      foreach (directed[i]) send(directed[i]);
      set_types(ntc_pkg::TY_F32, ntc_pkg::TY_I64);
      foreach (directed[i]) send(directed[i]);
      set_types(ntc_pkg::TY_I64, ntc_pkg::TY_F32);
      foreach (directed[i]) send(directed[i]);

      // Random part in three idling regimes; every type pairing is visited
      // in each, so all sixteen settings, extremes included, are covered.
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 58 : 0;
         recv_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 21 : 0;
         for (int k = 0; k < 16; k++) begin
            set_types(tys[k / 4], tys[k % 4]);
            for (int n = 0; n < 17; n++) begin
               send(random_value());
               // Once in each phase the sender holds off until the pipe is empty.
               if (n == 8 && k == 5) drain();
            end
         end
      end

      drain();
      $display("Covered %0d checked results over %0d type settings,", checked,
               settings_seen);
      $display("with sender and receiver stalls in both balances and without.");
      if (mismatches == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("tb: errors");
      $finish;
   end
endmodule

>>> sim.f
hw/rtl/ntc_pkg.sv
hw/rtl/ntc_stage.sv
hw/rtl/numeric_type_cast.sv
hw/rtl/ntc_checker.sv
tb/ntc_checker.sv
tb/tb.sv
